// ===== src/psra_pkg.sv =====
// Shared widths and request codes for the power state residency accumulator.
// No dependencies.
package psra_pkg;

  localparam int REQ_W   = 3;
  localparam int PROC_W  = 1;
  localparam int EVENT_W = 2;
  localparam int STATE_W = 3;
  localparam int TIME_W  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHANGE    = 3'd0,
    REQ_SET_STATE = 3'd1,
    REQ_LOG_EN    = 3'd2,
    REQ_READOUT   = 3'd3,
    REQ_ADD       = 3'd4,
    REQ_CLEAR     = 3'd5,
    REQ_SET_ENTRY = 3'd6
  } req_code_t;

endpackage

// ===== src/psra_req_if.sv =====
// Request channel: valid/ready handshake carrying one request item.
// Depends on psra_pkg.
interface psra_req_if import psra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [PROC_W-1:0]  proc_index;
  logic [EVENT_W-1:0] event_index;
  logic [STATE_W-1:0] new_state;
  logic [TIME_W-1:0]  cur_time;
  logic [TIME_W-1:0]  amount;
  logic               enable_flag;
  logic               all_events;

  modport source (
    output valid, req_type, proc_index, event_index, new_state, cur_time, amount,
           enable_flag, all_events,
    input  ready
  );
  modport sink (
    input  valid, req_type, proc_index, event_index, new_state, cur_time, amount,
           enable_flag, all_events,
    output ready
  );
endinterface

// ===== src/psra_rsp_if.sv =====
// Readout channel: valid/ready handshake carrying one accumulator item.
// Depends on psra_pkg.
interface psra_rsp_if import psra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PROC_W-1:0]  entry_proc;
  logic [EVENT_W-1:0] entry_event;
  logic [STATE_W-1:0] entry_state;
  logic [TIME_W-1:0]  duration;
  logic               last_entry;

  modport source (
    output valid, entry_proc, entry_event, entry_state, duration, last_entry,
    input  ready
  );
  modport sink (
    input  valid, entry_proc, entry_event, entry_state, duration, last_entry,
    output ready
  );
endinterface

// ===== src/power_state_residency_accumulator_core.sv =====
// Top level of the power state residency accumulator.
// Depends on psra_pkg, psra_req_if, psra_rsp_if and psra_ram.
//
// Usage:
//   req carries one request item per valid/ready handshake; rsp carries the
//   accumulator items of a readout, one per handshake, the final one marked
//   by last_entry. Only readout produces items.
// Timing:
//   One request is processed at a time; req.ready is high only while idle.
//   Set state, clear, set entry, ignored codes and add or change to an
//   unused slot end in the execute state; add then reads and writes the
//   accumulator; change reads the stamp, reads and writes the accumulator
//   when time is credited, then writes the stamp. Log enable sweeps the
//   stamp memory, one event per cycle. Readout first credits time for each
//   event in turn, then reads, loads and hands over each accumulator item,
//   waiting for rsp.ready on each.
// Reset:
//   Synchronous rst clears all states, flags, stamps and accumulators at
//   once through per-entry valid bits; no clearing pass is needed.
// Stall:
//   An emitted item stays in the output register until rsp.ready; the
//   readout pauses meanwhile and no request is taken until it completes.
module power_state_residency_accumulator_core import psra_pkg::*; #(
  parameter int NUM_PROCS  = 2,
  parameter int NUM_EVENTS = 4,
  parameter int NUM_STATES = 8
) (
  input logic        clk,
  input logic        rst,
  psra_req_if.sink   req,
  psra_rsp_if.source rsp
);

  localparam int EV_SLOTS  = NUM_PROCS * NUM_EVENTS;
  localparam int ACC_SLOTS = EV_SLOTS * NUM_STATES;
  localparam int EV_W      = (EV_SLOTS > 1) ? $clog2(EV_SLOTS) : 1;
  localparam int ACC_W     = $clog2(ACC_SLOTS);
  localparam int P_W       = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_STAMP,
    S_TRD,
    S_TDATA,
    S_AWR,
    S_ERD,
    S_ELOAD,
    S_EWAIT
  } state_t;

  state_t             state;
  req_code_t          req_q;
  logic [STATE_W-1:0] ns_q;
  logic [TIME_W-1:0]  time_q;
  logic [TIME_W-1:0]  amount_q;
  logic               en_q;
  logic               all_q;
  logic               ok_q;
  logic [EV_W-1:0]    ev_slot_q;
  logic [ACC_W-1:0]   acc_addr_q;
  logic [TIME_W-1:0]  addend_q;
  logic [P_W-1:0]     p_cnt;
  logic [EVENT_W-1:0] e_cnt;
  logic [STATE_W-1:0] s_cnt;

  logic [STATE_W-1:0] cur_state [EV_SLOTS];
  logic [EV_SLOTS-1:0]  log_en;
  logic [EV_SLOTS-1:0]  frozen;
  logic [EV_SLOTS-1:0]  time_vld;
  logic [ACC_SLOTS-1:0] acc_vld;

  logic               rsp_valid;
  logic [PROC_W-1:0]  rsp_proc;
  logic [EVENT_W-1:0] rsp_event;
  logic [STATE_W-1:0] rsp_state;
  logic [TIME_W-1:0]  rsp_duration;
  logic               rsp_last;

  logic               t_we;
  logic [EV_W-1:0]    t_waddr;
  logic [TIME_W-1:0]  t_wdata;
  logic [EV_W-1:0]    t_raddr;
  logic [TIME_W-1:0]  t_rdata;
  logic               a_we;
  logic [ACC_W-1:0]   a_waddr;
  logic [TIME_W-1:0]  a_wdata;
  logic [ACC_W-1:0]   a_raddr;
  logic [TIME_W-1:0]  a_rdata;

  logic               in_accept;
  logic               in_ok;
  logic [EV_W-1:0]    in_slot;
  logic [STATE_W-1:0] slot_state;
  logic               ns_ok;
  logic               cur_ok;
  logic               credit;
  logic [ACC_W-1:0]   req_acc;
  logic [ACC_W-1:0]   credit_acc;
  logic [TIME_W-1:0]  time_val;
  logic [TIME_W-1:0]  acc_val;
  logic               ev_done;
  logic               ev_last;
  logic               acc_last;

  psra_ram #(.WIDTH(TIME_W), .DEPTH(EV_SLOTS)) u_time_ram (
    .clk  (clk),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wdata),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  psra_ram #(.WIDTH(TIME_W), .DEPTH(ACC_SLOTS)) u_acc_ram (
    .clk  (clk),
    .we   (a_we),
    .waddr(a_waddr),
    .wdata(a_wdata),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign in_accept       = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.entry_proc  = rsp_proc;
  assign rsp.entry_event = rsp_event;
  assign rsp.entry_state = rsp_state;
  assign rsp.duration    = rsp_duration;
  assign rsp.last_entry  = rsp_last;

  assign in_ok = (int'(req.proc_index) < NUM_PROCS) && (int'(req.event_index) < NUM_EVENTS);
  assign in_slot = EV_W'(int'(req.proc_index) * NUM_EVENTS + int'(req.event_index));

  assign slot_state = cur_state[ev_slot_q];
  assign ns_ok      = int'(ns_q) < NUM_STATES;
  assign cur_ok     = int'(slot_state) < NUM_STATES;
  assign req_acc    = ACC_W'(int'(ev_slot_q) * NUM_STATES + int'(ns_q));
  assign credit_acc = ACC_W'(int'(ev_slot_q) * NUM_STATES + int'(slot_state));
  assign credit     = cur_ok && log_en[ev_slot_q] &&
                      ((req_q == REQ_CHANGE) || !frozen[ev_slot_q]);
  assign time_val   = time_vld[ev_slot_q] ? t_rdata : '0;
  assign acc_val    = acc_vld[acc_addr_q] ? a_rdata : '0;
  assign ev_last    = (int'(ev_slot_q) == EV_SLOTS - 1);
  assign acc_last   = (int'(acc_addr_q) == ACC_SLOTS - 1);

  always_comb begin
    t_we    = 1'b0;
    t_waddr = ev_slot_q;
    t_wdata = time_q;
    t_raddr = ev_slot_q;
    a_we    = 1'b0;
    a_waddr = acc_addr_q;
    a_wdata = acc_val + addend_q;
    a_raddr = acc_addr_q;
    ev_done = 1'b0;
    case (state)
      S_EXEC: begin
        a_raddr = req_acc;
        a_waddr = req_acc;
        case (req_q)
          REQ_CLEAR: begin
            a_we    = ok_q && ns_ok;
            a_wdata = '0;
          end
          REQ_SET_ENTRY: begin
            a_we    = ok_q && ns_ok;
            a_wdata = amount_q;
          end
          default: ;
        endcase
      end
      S_STAMP: t_we = 1'b1;
      S_TDATA: begin
        if (credit) begin
          a_raddr = credit_acc;
        end else begin
          t_we    = 1'b1;
          ev_done = 1'b1;
        end
      end
      S_AWR: begin
        a_we = 1'b1;
        if (req_q != REQ_ADD) begin
          t_we    = 1'b1;
          ev_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      log_en    <= '0;
      frozen    <= '0;
      time_vld  <= '0;
      acc_vld   <= '0;
      for (int i = 0; i < EV_SLOTS; i++) begin
        cur_state[i] <= '0;
      end
    end else begin
      if (t_we) begin
        time_vld[t_waddr] <= 1'b1;
      end
      if (a_we) begin
        acc_vld[a_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_q     <= req_code_t'(req.req_type);
            ns_q      <= req.new_state;
            time_q    <= req.cur_time;
            amount_q  <= req.amount;
            en_q      <= req.enable_flag;
            all_q     <= req.all_events;
            ok_q      <= in_ok;
            ev_slot_q <= in_slot;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (req_q)
            REQ_CHANGE: begin
              if (ok_q) begin
                state <= S_TRD;
              end else begin
                state <= S_IDLE;
              end
            end
            REQ_SET_STATE: begin
              if (ok_q) begin
                cur_state[ev_slot_q] <= ns_q;
              end
              state <= S_IDLE;
            end
            REQ_LOG_EN: begin
              if (all_q) begin
                log_en <= {EV_SLOTS{en_q}};
              end else if (ok_q) begin
                log_en[ev_slot_q] <= en_q;
              end
              ev_slot_q <= '0;
              state     <= S_STAMP;
            end
            REQ_READOUT: begin
              ev_slot_q <= '0;
              state     <= S_TRD;
            end
            REQ_ADD: begin
              if (ok_q && ns_ok) begin
                acc_addr_q <= req_acc;
                addend_q   <= amount_q;
                state      <= S_AWR;
              end else begin
                state <= S_IDLE;
              end
            end
            REQ_SET_ENTRY: begin
              if (ok_q && ns_ok) begin
                frozen[ev_slot_q] <= 1'b1;
              end
              state <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_STAMP: begin
          if (ev_last) begin
            state <= S_IDLE;
          end else begin
            ev_slot_q <= ev_slot_q + 1'b1;
          end
        end
        S_TRD: state <= S_TDATA;
        S_TDATA: begin
          if (credit) begin
            acc_addr_q <= credit_acc;
            addend_q   <= time_q - time_val;
            state      <= S_AWR;
          end
        end
        S_AWR: begin
          if (req_q == REQ_ADD) begin
            state <= S_IDLE;
          end
        end
        S_ERD: state <= S_ELOAD;
        S_ELOAD: begin
          rsp_valid           <= 1'b1;
          rsp_proc            <= p_cnt[PROC_W-1:0];
          rsp_event           <= e_cnt;
          rsp_state           <= s_cnt;
          rsp_duration        <= acc_val;
          rsp_last            <= acc_last;
          acc_vld[acc_addr_q] <= 1'b0;
          state               <= S_EWAIT;
        end
        S_EWAIT: begin
          if (rsp.ready) begin
            rsp_valid <= 1'b0;
            if (acc_last) begin
              state <= S_IDLE;
            end else begin
              acc_addr_q <= acc_addr_q + 1'b1;
              state      <= S_ERD;
              if (int'(s_cnt) == NUM_STATES - 1) begin
                s_cnt <= '0;
                if (int'(e_cnt) == NUM_EVENTS - 1) begin
                  e_cnt <= '0;
                  p_cnt <= p_cnt + 1'b1;
                end else begin
                  e_cnt <= e_cnt + 1'b1;
                end
              end else begin
                s_cnt <= s_cnt + 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (ev_done) begin
        if (req_q == REQ_CHANGE) begin
          cur_state[ev_slot_q] <= ns_q;
          state                <= S_IDLE;
        end else if (ev_last) begin
          acc_addr_q <= '0;
          p_cnt      <= '0;
          e_cnt      <= '0;
          s_cnt      <= '0;
          state      <= S_ERD;
        end else begin
          ev_slot_q <= ev_slot_q + 1'b1;
          state     <= S_TRD;
        end
      end
    end
  end

endmodule

// ===== src/psra_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module psra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
